>>> hw/rtl/cfe_pkg.sv
package cfe_pkg;

    // Field and register widths
    localparam int FACE_W      = 3;
    localparam int PIX_W       = 12;
    localparam int SIZE_W      = 13;
    localparam int FOCAL_W     = 24;
    localparam int ERP_W       = 15;
    localparam int SRC_X_W     = 22;
    localparam int SRC_Y_W     = 23;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    // Defaults for the top level parameters
    localparam int DEF_MAX_FACE_SIZE = 4096;
    localparam int DEF_MAX_ERP_SIZE  = 16384;
    localparam int DEF_FRAC_BITS     = 8;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FACE_SIZE    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_LENGTH = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ERP_WIDTH    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ERP_HEIGHT   = 4'd3;

    // Face codes
    localparam logic [FACE_W-1:0] FACE_F = 3'd0;
    localparam logic [FACE_W-1:0] FACE_B = 3'd1;
    localparam logic [FACE_W-1:0] FACE_L = 3'd2;
    localparam logic [FACE_W-1:0] FACE_R = 3'd3;
    localparam logic [FACE_W-1:0] FACE_U = 3'd4;
    localparam logic [FACE_W-1:0] FACE_D = 3'd5;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam int RAY_W        = 31;
    localparam logic [29:0] KINV_Q30 = 30'd652032874;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] LAT_WRAP     = 32'hC000_0000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          ang;
    } cordic_t;

    // atan(2^-i) as binary angle, full turn = 2^32
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/cfe_cordic_stage.sv
module cfe_cordic_stage #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  cfe_pkg::cordic_t    in_vec,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output cfe_pkg::cordic_t    out_vec,
    output logic [SIDE_W-1:0]   out_side
);

    logic                          valid_reg;
    cfe_pkg::cordic_t              vec_reg, vec_next;
    logic [SIDE_W-1:0]             side_reg;
    logic signed [cfe_pkg::CW-1:0] dx, dy;
    logic                          y_pos;

    // One vectoring micro-rotation, shifts are arithmetic
    always_comb begin
        dx    = in_vec.y >>> STEP;
        dy    = in_vec.x >>> STEP;
        y_pos = !in_vec.y[cfe_pkg::CW-1] && (in_vec.y != '0);
        if (y_pos) begin
            vec_next.x   = in_vec.x + dx;
            vec_next.y   = in_vec.y - dy;
            vec_next.ang = in_vec.ang + cfe_pkg::atan_entry(STEP);
        end else begin
            vec_next.x   = in_vec.x - dx;
            vec_next.y   = in_vec.y + dy;
            vec_next.ang = in_vec.ang - cfe_pkg::atan_entry(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

>>> hw/rtl/cube_face_to_equirect_coord.sv
// Cube face pixel to equirectangular source coordinate.
// Input channel (s_valid/s_ready): one word per face pixel, s_face, s_col, s_row.
// Result channel (m_valid/m_ready): one word per input, m_src_x and m_src_y in
// fixed point with FRAC_BITS fraction bits.
// Config channel (cfg_valid/cfg_ready): cfg_index selects face side (0),
// focal_length (1), erp_width (2), erp_height (3); always ready. Write it only
// while the pipeline is empty.
// Throughput is one word per cycle while the receiver does not stall. The
// depth is set by the two 30-step pipelined CORDIC chains (longitude, then
// latitude), plus normalize, multiply and scale stages.
// Reset clears all valid bits and loads the config defaults 1024, 131072,
// 4096, 2048. When the receiver stalls, the whole pipeline holds and s_ready
// drops in the same cycle; nothing is lost or repeated.
module cube_face_to_equirect_coord #(
    parameter int MAX_FACE_SIZE = cfe_pkg::DEF_MAX_FACE_SIZE,
    parameter int MAX_ERP_SIZE  = cfe_pkg::DEF_MAX_ERP_SIZE,
    parameter int FRAC_BITS     = cfe_pkg::DEF_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cfe_pkg::FACE_W-1:0]      s_face,
    input  logic [cfe_pkg::PIX_W-1:0]       s_col,
    input  logic [cfe_pkg::PIX_W-1:0]       s_row,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cfe_pkg::SRC_X_W-1:0]     m_src_x,
    output logic [cfe_pkg::SRC_Y_W-1:0]     m_src_y,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW    = cfe_pkg::CW;
    localparam int RW    = cfe_pkg::RAY_W;
    localparam int NS    = cfe_pkg::CORDIC_STEPS;
    localparam int SHX   = 32 - FRAC_BITS;
    localparam int SHY   = 31 - FRAC_BITS;
    localparam int PW    = 32 + cfe_pkg::ERP_W;

    logic en;

    // Config registers
    logic [cfe_pkg::SIZE_W-1:0]  side_len_reg;
    logic [cfe_pkg::FOCAL_W-1:0] focal_length_reg;
    logic [cfe_pkg::ERP_W-1:0]   erp_width_reg, erp_height_reg;
    logic [cfe_pkg::SIZE_W-1:0]  s_sat;
    logic [cfe_pkg::ERP_W-1:0]   w_sat, h_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_len_reg     <= 13'd1024;
            focal_length_reg <= 24'd131072;
            erp_width_reg    <= 15'd4096;
            erp_height_reg   <= 15'd2048;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cfe_pkg::REG_FACE_SIZE:    side_len_reg     <= cfg_data[cfe_pkg::SIZE_W-1:0];
                cfe_pkg::REG_FOCAL_LENGTH: focal_length_reg <= cfg_data;
                cfe_pkg::REG_ERP_WIDTH:    erp_width_reg    <= cfg_data[cfe_pkg::ERP_W-1:0];
                cfe_pkg::REG_ERP_HEIGHT:   erp_height_reg   <= cfg_data[cfe_pkg::ERP_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate to the supported sizes
    assign s_sat = (32'(side_len_reg) > 32'(MAX_FACE_SIZE)) ?
                   cfe_pkg::SIZE_W'(MAX_FACE_SIZE) : side_len_reg;
    assign w_sat = (32'(erp_width_reg) > 32'(MAX_ERP_SIZE)) ?
                   cfe_pkg::ERP_W'(MAX_ERP_SIZE) : erp_width_reg;
    assign h_sat = (32'(erp_height_reg) > 32'(MAX_ERP_SIZE)) ?
                   cfe_pkg::ERP_W'(MAX_ERP_SIZE) : erp_height_reg;

    // Global advance: the output register empties or is taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 0: pinhole ray in 1/256 pixel
    logic                          v0_reg;
    logic [cfe_pkg::FACE_W-1:0]    face0_reg;
    logic signed [21:0]            fx0_reg, fy0_reg;
    logic [cfe_pkg::FOCAL_W-1:0]   fz0_reg;
    logic signed [14:0]            cx, cy;

    always_comb begin
        cx = $signed({2'b00, s_col, 1'b1}) - $signed({2'b00, s_sat});
        cy = $signed({2'b00, s_row, 1'b1}) - $signed({2'b00, s_sat});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            face0_reg <= s_face;
            fx0_reg   <= {cx, 7'b0};
            fy0_reg   <= {cy, 7'b0};
            fz0_reg   <= focal_length_reg;
        end
    end

    // Stage 1: largest component magnitude
    logic                          v1_reg;
    logic [cfe_pkg::FACE_W-1:0]    face1_reg;
    logic signed [21:0]            fx1_reg, fy1_reg;
    logic [cfe_pkg::FOCAL_W-1:0]   fz1_reg, m1_reg;
    logic [21:0]                   ax, ay;
    logic [cfe_pkg::FOCAL_W-1:0]   m_next;

    always_comb begin
        ax = fx0_reg[21] ? 22'(-fx0_reg) : 22'(fx0_reg);
        ay = fy0_reg[21] ? 22'(-fy0_reg) : 22'(fy0_reg);
        m_next = {2'b00, ax};
        if (ay > ax) begin
            m_next = {2'b00, ay};
        end
        if (fz0_reg > m_next) begin
            m_next = fz0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            face1_reg <= face0_reg;
            fx1_reg   <= fx0_reg;
            fy1_reg   <= fy0_reg;
            fz1_reg   <= fz0_reg;
            m1_reg    <= m_next;
        end
    end

    // Stage 2: normalize shift, largest magnitude into [2^28, 2^29)
    logic                          v2_reg;
    logic [cfe_pkg::FACE_W-1:0]    face2_reg;
    logic signed [21:0]            fx2_reg, fy2_reg;
    logic [cfe_pkg::FOCAL_W-1:0]   fz2_reg;
    logic [4:0]                    sh2_reg, sh_next;

    always_comb begin
        sh_next = 5'd0;
        for (int i = 0; i < cfe_pkg::FOCAL_W; i++) begin
            if (m1_reg[i]) begin
                sh_next = 5'(28 - i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            face2_reg <= face1_reg;
            fx2_reg   <= fx1_reg;
            fy2_reg   <= fy1_reg;
            fz2_reg   <= fz1_reg;
            sh2_reg   <= sh_next;
        end
    end

    // Stage 3: scale and rotate into the face frame
    logic                    v3_reg;
    logic signed [RW-1:0]    sx3_reg, sy3_reg, sz3_reg;
    logic signed [RW-1:0]    qx, qy, qz;
    logic signed [RW-1:0]    rx, ry, rz;

    always_comb begin
        qx = RW'(fx2_reg) <<< sh2_reg;
        qy = RW'(fy2_reg) <<< sh2_reg;
        qz = $signed({7'b0, fz2_reg}) <<< sh2_reg;
        case (face2_reg)
            cfe_pkg::FACE_B: begin rx = -qx; ry = qy;  rz = -qz; end
            cfe_pkg::FACE_L: begin rx = -qz; ry = qy;  rz = qx;  end
            cfe_pkg::FACE_R: begin rx = qz;  ry = qy;  rz = -qx; end
            cfe_pkg::FACE_U: begin rx = qx;  ry = -qz; rz = qy;  end
            cfe_pkg::FACE_D: begin rx = qx;  ry = qz;  rz = -qy; end
            default:         begin rx = qx;  ry = qy;  rz = qz;  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx3_reg <= rx;
            sy3_reg <= ry;
            sz3_reg <= rz;
        end
    end

    // Stage 4: longitude CORDIC setup, half turn for negative z
    localparam int SIDE1_W = RW + 1;
    cfe_pkg::cordic_t      c1_vec  [0:NS];
    logic [SIDE1_W-1:0]    c1_side [0:NS];
    logic                  c1_valid[0:NS];
    cfe_pkg::cordic_t      init1_next;
    logic                  skip1;

    always_comb begin
        skip1 = (sx3_reg == '0) && (sz3_reg == '0);
        if (sz3_reg[RW-1]) begin
            init1_next.x   = -CW'(sz3_reg);
            init1_next.y   = -CW'(sx3_reg);
            init1_next.ang = cfe_pkg::HALF_TURN;
        end else begin
            init1_next.x   = CW'(sz3_reg);
            init1_next.y   = CW'(sx3_reg);
            init1_next.ang = '0;
        end
    end

    logic                  v4_reg;
    cfe_pkg::cordic_t      init1_reg;
    logic [SIDE1_W-1:0]    side1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            init1_reg <= init1_next;
            side1_reg <= {sy3_reg, skip1};
        end
    end

    assign c1_vec[0]   = init1_reg;
    assign c1_side[0]  = side1_reg;
    assign c1_valid[0] = v4_reg;

    for (genvar i = 0; i < NS; i++) begin : g_lon
        cfe_cordic_stage #(.STEP(i), .SIDE_W(SIDE1_W)) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (c1_valid[i]),
            .in_vec   (c1_vec[i]),
            .in_side  (c1_side[i]),
            .out_valid(c1_valid[i+1]),
            .out_vec  (c1_vec[i+1]),
            .out_side (c1_side[i+1])
        );
    end

    // Stage 5: hypot(x,z) = magnitude / K, longitude with pole ray forced to 0
    logic                  v5_reg;
    logic [31:0]           hyp5_reg, lon5_reg;
    logic signed [RW-1:0]  sy5_reg;
    logic                  skip1_end;
    logic [61:0]           hyp_prod;

    always_comb begin
        skip1_end = c1_side[NS][0];
        hyp_prod  = c1_vec[NS].x[31:0] * cfe_pkg::KINV_Q30;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hyp5_reg <= skip1_end ? 32'd0 : hyp_prod[61:30];
            lon5_reg <= skip1_end ? 32'd0 : c1_vec[NS].ang;
            sy5_reg  <= $signed(c1_side[NS][SIDE1_W-1:1]);
        end
    end

    // Stage 6: latitude CORDIC setup
    localparam int SIDE2_W = 33;
    cfe_pkg::cordic_t      c2_vec  [0:NS];
    logic [SIDE2_W-1:0]    c2_side [0:NS];
    logic                  c2_valid[0:NS];
    logic                  v6_reg;
    cfe_pkg::cordic_t      init2_reg;
    logic [SIDE2_W-1:0]    side2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            init2_reg.x   <= $signed({2'b00, hyp5_reg});
            init2_reg.y   <= -CW'(sy5_reg);
            init2_reg.ang <= '0;
            side2_reg     <= {lon5_reg, (hyp5_reg == '0) && (sy5_reg == '0)};
        end
    end

    assign c2_vec[0]   = init2_reg;
    assign c2_side[0]  = side2_reg;
    assign c2_valid[0] = v6_reg;

    for (genvar i = 0; i < NS; i++) begin : g_lat
        cfe_cordic_stage #(.STEP(i), .SIDE_W(SIDE2_W)) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (c2_valid[i]),
            .in_vec   (c2_vec[i]),
            .in_side  (c2_side[i]),
            .out_valid(c2_valid[i+1]),
            .out_vec  (c2_vec[i+1]),
            .out_side (c2_side[i+1])
        );
    end

    // Stage 7: angle offsets, latitude clamp to [0, half turn]
    logic          v7_reg;
    logic [31:0]   a7_reg, c7_reg;
    logic [31:0]   lat, c_next;

    always_comb begin
        lat    = c2_side[NS][0] ? 32'd0 : c2_vec[NS].ang;
        c_next = cfe_pkg::QUARTER_TURN - lat;
        if (c_next > cfe_pkg::LAT_WRAP) begin
            c_next = 32'd0;
        end else if (c_next > cfe_pkg::HALF_TURN) begin
            c_next = cfe_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a7_reg <= c2_side[NS][SIDE2_W-1:1] + cfe_pkg::HALF_TURN;
            c7_reg <= c_next;
        end
    end

    // Stage 8: scale to image size, output register
    logic                        m_valid_reg;
    logic [cfe_pkg::SRC_X_W-1:0] src_x_reg;
    logic [cfe_pkg::SRC_Y_W-1:0] src_y_reg;
    logic [PW-1:0]               px, py, px_sh, py_sh;

    always_comb begin
        px    = a7_reg * w_sat;
        py    = c7_reg * h_sat;
        px_sh = px >> SHX;
        py_sh = py >> SHY;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            src_x_reg <= px_sh[cfe_pkg::SRC_X_W-1:0];
            src_y_reg <= py_sh[cfe_pkg::SRC_Y_W-1:0];
        end
    end

    // Valid bits of the non-CORDIC stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v0_reg      <= s_valid;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= c1_valid[NS];
            v6_reg      <= v5_reg;
            v7_reg      <= c2_valid[NS];
            m_valid_reg <= v7_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_src_x = src_x_reg;
    assign m_src_y = src_y_reg;

`ifndef ASSERT_OFF
    // A stalled output must block intake
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while output stalled");

    // Pipeline occupancy holds during a stall
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(v7_reg) && $stable(v0_reg)
                                   && $stable(c1_valid[NS]) && $stable(c2_valid[NS])))
        else $error("pipeline moved during stall");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule
